/* src/bpc_pkg.sv */
// bpc_pkg: shared widths, codes, register indexes and types of the button press classifier.
// No dependencies; every other file of the block but bpc_if imports it.

package bpc_pkg;

   // Press timer width and derived widths
   localparam int TIMER_WIDTH = 32;
   localparam int CMP_WIDTH   = (TIMER_WIDTH > 32) ? TIMER_WIDTH : 32;
   localparam int SUM_WIDTH   = ((TIMER_WIDTH > 16) ? TIMER_WIDTH : 16) + 1;

   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
   localparam logic [31:0]            HELD_MAX  = 32'hFFFF_FFFF;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_ENABLED    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICK_UNIT        = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SHORT_PRESS_TIME = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TIME  = 2'd3;

   localparam logic [15:0] TICK_UNIT_RESET        = 16'd10;
   localparam logic [31:0] SHORT_PRESS_TIME_RESET = 32'd50;
   localparam logic [31:0] LONG_PRESS_TIME_RESET  = 32'd1000;

   // Event codes reported on the result channel
   typedef enum logic [1:0] {
      EV_PRESSED        = 2'd0,
      EV_LONG_PRESSED   = 2'd1,
      EV_SHORT_RELEASED = 2'd2,
      EV_LONG_RELEASED  = 2'd3
   } event_code_type;

   // Press tracking state, one-hot
   typedef enum logic [4:0] {
      ST_RELEASED       = 5'b00001,
      ST_PRESSED        = 5'b00010,
      ST_LONG_PRESSED   = 5'b00100,
      ST_SHORT_RELEASED = 5'b01000,
      ST_LONG_RELEASED  = 5'b10000
   } press_state_type;

   // Register file contents as seen by the engine
   typedef struct packed {
      logic        block_enabled;
      logic [15:0] tick_unit;
      logic [31:0] short_press_time;
      logic [31:0] long_press_time;
   } cfg_type;

   // Event raised by the engine for one tick
   typedef struct packed {
      logic           hit;
      event_code_type code;
      logic [31:0]    held_time;
   } event_type;

endpackage

/* src/bpc_if.sv */
// bpc_if: valid/ready channel interfaces for tick words and event words.
// Depends on nothing; payload widths follow the block's field list.

interface bpc_req_if;
   logic valid;
   logic ready;
   logic pressed;

   modport source (output valid, output pressed, input ready);
   modport sink   (input valid, input pressed, output ready);
endinterface

interface bpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_code;
   logic [31:0] held_time;

   modport source (output valid, output event_code, output held_time, input ready);
   modport sink   (input valid, input event_code, input held_time, output ready);
endinterface

/* src/button_press_classifier_core.sv */
// button_press_classifier_core: top level of the button press classifier.
// Depends on bpc_pkg, bpc_if, bpc_csr and bpc_engine.
//
// Usage
//   req_chan carries one word per polling tick: the sampled button level.
//   rsp_chan carries at most one event word per tick: event code and held time.
//   csr_wr_en/csr_index/csr_wdata write the enable, tick unit and both
//   thresholds; write them only while no tick is in flight.
// Timing
//   A tick word goes into an input register, is evaluated against the timer
//   and press state once the output register is free or being drained, and
//   its event lands in the output register, from which rsp_chan takes it.
//   One tick per cycle is taken while the output register is free or drained,
//   set by the single timer add and compare between the input and output
//   registers.
// Reset
//   Both registers empty, timer zero and running, state released, block
//   disabled, tick unit 10, press threshold 50, long press threshold 1000.
// Back-pressure
//   While an event waits on rsp_chan the input register still holds one more
//   tick; req_chan.ready drops only when both are occupied.

module button_press_classifier_core
   import bpc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   bpc_req_if.sink                    req_chan,
   bpc_rsp_if.source                  rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type   cfg;
   event_type evt;

   logic           in_valid_ff, in_valid_in;
   logic           in_pressed_ff;
   logic           out_valid_ff, out_valid_in;
   event_code_type out_code_ff;
   logic [31:0]    out_held_ff;
   logic           advance;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (advance),
      .pressed (in_pressed_ff),
      .evt     (evt)
   );

   // the held tick moves on when the output register is free or being drained
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = evt.hit;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_pressed_ff <= req_chan.pressed;
      end
      if (advance && evt.hit) begin
         out_code_ff <= evt.code;
         out_held_ff <= evt.held_time;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.event_code = out_code_ff;
   assign rsp_chan.held_time  = out_held_ff;

endmodule

/* src/bpc_csr.sv */
// bpc_csr: configuration register file of the button press classifier.
// Depends on bpc_pkg.

module bpc_csr
   import bpc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BLOCK_ENABLED:    cfg_in.block_enabled    = csr_wdata[0];
            CSR_TICK_UNIT:        cfg_in.tick_unit        = csr_wdata[15:0];
            CSR_SHORT_PRESS_TIME: cfg_in.short_press_time = csr_wdata[31:0];
            CSR_LONG_PRESS_TIME:  cfg_in.long_press_time  = csr_wdata[31:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.block_enabled    <= 1'b0;
         cfg_ff.tick_unit        <= TICK_UNIT_RESET;
         cfg_ff.short_press_time <= SHORT_PRESS_TIME_RESET;
         cfg_ff.long_press_time  <= LONG_PRESS_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/bpc_engine.sv */
// bpc_engine: press timer, press state and event decision for one tick per cycle.
// Depends on bpc_pkg.

module bpc_engine
   import bpc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      step,     // a tick word is processed this cycle
   input  logic      pressed,
   output event_type evt
);

   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic                   running_ff, running_in;
   press_state_type        state_ff, state_in;

   logic [SUM_WIDTH-1:0]   sum;
   logic [TIMER_WIDTH-1:0] grown;
   logic [TIMER_WIDTH-1:0] held_src;
   logic [CMP_WIDTH-1:0]   grown_cmp, timer_cmp, short_cmp, long_cmp, held_cmp;
   logic [31:0]            held_time;

   // saturating timer growth
   assign sum   = SUM_WIDTH'(timer_ff) + SUM_WIDTH'(cfg.tick_unit);
   assign grown = (sum > SUM_WIDTH'(TIMER_MAX)) ? TIMER_MAX : sum[TIMER_WIDTH-1:0];

   assign grown_cmp = CMP_WIDTH'(grown);
   assign timer_cmp = CMP_WIDTH'(timer_ff);
   assign short_cmp = CMP_WIDTH'(cfg.short_press_time);
   assign long_cmp  = CMP_WIDTH'(cfg.long_press_time);

   // held time is reported clipped to 32 bits: grown timer on a held tick,
   // timer before clearing on a released one
   assign held_src  = pressed ? grown : timer_ff;
   assign held_cmp  = CMP_WIDTH'(held_src);
   assign held_time = (held_cmp > CMP_WIDTH'(HELD_MAX)) ? HELD_MAX : held_cmp[31:0];

   // tick decision
   always_comb begin
      timer_in      = timer_ff;
      running_in    = running_ff;
      state_in      = state_ff;
      evt.hit       = 1'b0;
      evt.code      = EV_PRESSED;
      evt.held_time = held_time;
      if (step && cfg.block_enabled) begin
         if (pressed) begin
            if (running_ff) begin
               timer_in = grown;
               if (grown_cmp >= long_cmp && state_ff != ST_LONG_PRESSED) begin
                  running_in = 1'b0;
                  state_in   = ST_LONG_PRESSED;
                  evt.hit    = 1'b1;
                  evt.code   = EV_LONG_PRESSED;
               end else if (grown_cmp >= short_cmp && state_ff != ST_PRESSED) begin
                  state_in = ST_PRESSED;
                  evt.hit  = 1'b1;
                  evt.code = EV_PRESSED;
               end
            end
         end else begin
            if (timer_cmp >= long_cmp) begin
               state_in = ST_LONG_RELEASED;
               evt.hit  = 1'b1;
               evt.code = EV_LONG_RELEASED;
            end else if (timer_cmp >= short_cmp) begin
               state_in = ST_SHORT_RELEASED;
               evt.hit  = 1'b1;
               evt.code = EV_SHORT_RELEASED;
            end else begin
               state_in = ST_RELEASED;
            end
            timer_in   = '0;
            running_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff   <= '0;
         running_ff <= 1'b1;
         state_ff   <= ST_RELEASED;
      end else begin
         timer_ff   <= timer_in;
         running_ff <= running_in;
         state_ff   <= state_in;
      end
   end

   // a long press always freezes the timer
   a_long_frozen: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LONG_PRESSED |-> !running_ff)
      else $error("long press state with timer running");

   // a released tick clears the timer and restarts it
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      step && cfg.block_enabled && !pressed |=> timer_ff == '0 && running_ff)
      else $error("timer not cleared on release");

   // a frozen timer does not move while held
   a_frozen_stable: assert property (@(posedge clock) disable iff (reset)
      step && pressed && !running_ff |=> $stable(timer_ff))
      else $error("frozen timer moved");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for button_press_classifier_core.
// Depends on bpc_pkg, bpc_if and the core. Drives tick words, predicts the event
// words from its own copy of the press timer and checks every word that comes back.

module tb_top;
   import bpc_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_COUNT  = 12;
   localparam int PHASE_TICKS  = 65;

   logic                       clock;
   logic                       reset;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   bpc_req_if req_chan_if ();
   bpc_rsp_if rsp_chan_if ();

   button_press_classifier_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan_if),
      .rsp_chan  (rsp_chan_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow registers and press tracking mirrored from the block
   cfg_type                csr_shadow;
   logic [TIMER_WIDTH-1:0] hold_timer;
   logic                   hold_running;
   press_state_type        hold_state;

   event_type pending_events[$];
   int        error_count = 0;
   int        cycle_count = 0;
   bit        gaps_on     = 1'b1;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Event word as the block should report it from the current timer
   function automatic event_type make_event(input event_code_type code);
      event_type ev;
      ev.hit       = 1'b1;
      ev.code      = code;
      ev.held_time = (64'(hold_timer) > 64'(HELD_MAX)) ? HELD_MAX : 32'(hold_timer);
      return ev;
   endfunction

   // Advance the press timer by one tick; hit is set when an event is due
   function automatic event_type classify_tick(input logic pressed);
      event_type   ev;
      logic [64:0] sum;
      ev = '0;
      if (csr_shadow.block_enabled) begin
         if (pressed) begin
            // frozen after a long press until release
            if (hold_running) begin
               sum = 65'(hold_timer) + 65'(csr_shadow.tick_unit);
               hold_timer = (sum > 65'(TIMER_MAX)) ? TIMER_MAX : sum[TIMER_WIDTH-1:0];
               if (64'(hold_timer) >= 64'(csr_shadow.long_press_time) &&
                   hold_state != ST_LONG_PRESSED) begin
                  hold_running = 1'b0;
                  hold_state   = ST_LONG_PRESSED;
                  ev = make_event(EV_LONG_PRESSED);
               end else if (64'(hold_timer) >= 64'(csr_shadow.short_press_time) &&
                            hold_state != ST_PRESSED) begin
                  hold_state = ST_PRESSED;
                  ev = make_event(EV_PRESSED);
               end
            end
         end else begin
            if (64'(hold_timer) >= 64'(csr_shadow.long_press_time)) begin
               hold_state = ST_LONG_RELEASED;
               ev = make_event(EV_LONG_RELEASED);
            end else if (64'(hold_timer) >= 64'(csr_shadow.short_press_time)) begin
               hold_state = ST_SHORT_RELEASED;
               ev = make_event(EV_SHORT_RELEASED);
            end else begin
               hold_state = ST_RELEASED;
            end
            hold_timer   = '0;
            hold_running = 1'b1;
         end
      end
      return ev;
   endfunction

   // Sender idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // One register write; leaves the write enable low behind it
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (index)
         CSR_BLOCK_ENABLED:    csr_shadow.block_enabled    = data[0];
         CSR_TICK_UNIT:        csr_shadow.tick_unit        = data[15:0];
         CSR_SHORT_PRESS_TIME: csr_shadow.short_press_time = data[31:0];
         CSR_LONG_PRESS_TIME:  csr_shadow.long_press_time  = data[31:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic load_settings(input logic en, input logic [15:0] unit,
                                input logic [31:0] short_t, input logic [31:0] long_t);
      write_csr(CSR_BLOCK_ENABLED, {31'($urandom), en});
      write_csr(CSR_TICK_UNIT, {16'($urandom), unit});
      write_csr(CSR_SHORT_PRESS_TIME, short_t);
      write_csr(CSR_LONG_PRESS_TIME, long_t);
   endtask

   // Send one tick word; entered and left at a falling edge
   task automatic send_tick(input logic pressed);
      int        gap;
      event_type ev;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan_if.valid   = 1'b0;
         req_chan_if.pressed = 1'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_chan_if.valid   = 1'b1;
      req_chan_if.pressed = pressed;
      do @(posedge clock); while (!req_chan_if.ready);
      ev = classify_tick(pressed);
      if (ev.hit) pending_events.push_back(ev);
      @(negedge clock);
   endtask

   // Idle the sender until every event has come back and the pipe is empty
   task automatic wait_drain();
      req_chan_if.valid = 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Receiver: stretches of ready, short stalls, occasional long stalls
   initial begin
      int   span;
      int   r;
      logic level;
      rsp_chan_if.ready = 1'b0;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            level = 1'b1;
            span  = $urandom_range(5, 40);
         end else if (r < 85) begin
            level = 1'b0;
            span  = $urandom_range(1, 3);
         end else if (r < 95) begin
            level = 1'b1;
            span  = 1;
         end else begin
            level = 1'b0;
            span  = $urandom_range(10, 60);
         end
         repeat (span) begin
            @(negedge clock);
            rsp_chan_if.ready = level;
         end
      end
   end

   // Result checker: each event word against the oldest prediction
   always @(posedge clock) begin
      event_type want;
      if (!reset && rsp_chan_if.valid && rsp_chan_if.ready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event word, expected none actual code %0d held %0d",
                     $time, rsp_chan_if.event_code, rsp_chan_if.held_time);
            error_count++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_chan_if.event_code !== want.code) begin
               $display("%0t: event_code mismatch, expected %0d actual %0d",
                        $time, want.code, rsp_chan_if.event_code);
               error_count++;
            end
            if (rsp_chan_if.held_time !== want.held_time) begin
               $display("%0t: held_time mismatch, expected %0d actual %0d",
                        $time, want.held_time, rsp_chan_if.held_time);
               error_count++;
            end
         end
      end
   end

   // Disabled after reset: ticks leave no trace
   task automatic test_disabled();
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_drain();
   endtask

   // Reset values of unit and thresholds: press on the fifth held tick
   task automatic test_reset_values();
      write_csr(CSR_BLOCK_ENABLED, 32'd1);
      repeat (6) send_tick(1'b1);
      send_tick(1'b0);
      wait_drain();
   endtask

   // Zero short threshold, widest unit: idle release reports, first hold reports
   task automatic test_short_zero();
      load_settings(1'b1, 16'hFFFF, 32'd0, 32'hFFFF_FFFF);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_drain();
   endtask

   // Both thresholds crossed together, then held while frozen
   task automatic test_both_thresholds();
      load_settings(1'b1, 16'd20, 32'd5, 32'd10);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_drain();
   endtask

   // Unit of zero: timer stays at zero while held
   task automatic test_zero_unit();
      load_settings(1'b1, 16'd0, 32'd0, 32'd5);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_drain();
   endtask

   // Long back-to-back hold with the widest unit, past both thresholds and frozen
   task automatic test_long_hold();
      load_settings(1'b1, 16'hFFFF, 32'h0010_0000, 32'h0040_0000);
      gaps_on = 1'b0;
      repeat (80) send_tick(1'b1);
      send_tick(1'b0);
      gaps_on = 1'b1;
      wait_drain();
   endtask

   // Random phases: press/release runs with random content, some noise
   task automatic test_random_phases();
      int          sent;
      int          len;
      int          rel;
      int          k;
      bit          paused;
      logic [15:0] unit;
      logic [31:0] short_t;
      logic [31:0] long_t;
      logic [31:0] swap;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_drain();
         k = $urandom_range(0, 9);
         if (k == 0) unit = 16'hFFFF;
         else if (k == 1) unit = 16'd1;
         else if (k < 7) unit = 16'($urandom_range(1, 40));
         else unit = 16'($urandom) | 16'd1;
         short_t = 32'(unit) * 32'($urandom_range(0, 6));
         long_t  = short_t + 32'(unit) * 32'($urandom_range(0, 8));
         case ($urandom_range(0, 9))
            0: short_t = 32'd0;
            1: long_t = 32'd0;
            2: begin
               short_t = 32'hFFFF_FFFF;
               long_t  = 32'hFFFF_FFFF;
            end
            3: begin
               swap    = short_t;
               short_t = long_t;
               long_t  = swap;
            end
            4: begin
               short_t = $urandom;
               long_t  = $urandom;
            end
            default: ;
         endcase
         load_settings(ph != 5, unit, short_t, long_t);
         gaps_on = (ph % 4 != 2);
         sent    = 0;
         paused  = 1'b0;
         while (sent < PHASE_TICKS) begin
            if ($urandom_range(0, 9) < 2) begin
               send_tick(1'($urandom));
               sent++;
            end else begin
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30)
                                                 : $urandom_range(1, 12);
               rel = $urandom_range(1, 3);
               repeat (len) send_tick(1'b1);
               repeat (rel) send_tick(1'b0);
               sent += len + rel;
            end
            // hold the sender off until every pending event has come back
            if (ph == 3 && !paused && sent >= PHASE_TICKS / 2) begin
               req_chan_if.valid = 1'b0;
               while (pending_events.size() != 0) @(posedge clock);
               @(negedge clock);
               paused = 1'b1;
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   // Main sequence
   initial begin
      req_chan_if.valid   = 1'b0;
      req_chan_if.pressed = 1'b0;
      csr_wr_en           = 1'b0;
      csr_index           = CSR_BLOCK_ENABLED;
      csr_wdata           = '0;
      reset               = 1'b1;

      csr_shadow.block_enabled    = 1'b0;
      csr_shadow.tick_unit        = TICK_UNIT_RESET;
      csr_shadow.short_press_time = SHORT_PRESS_TIME_RESET;
      csr_shadow.long_press_time  = LONG_PRESS_TIME_RESET;
      hold_timer                  = '0;
      hold_running                = 1'b1;
      hold_state                  = ST_RELEASED;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_disabled();
      test_reset_values();
      test_short_zero();
      test_both_thresholds();
      test_zero_unit();
      test_long_hold();
      test_random_phases();
      wait_drain();

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
